@@ rtl/core/ftifc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed-to-float converter package
// Field widths, format codes and IEEE 754 constants shared by the converter.
// ----------------------------------------------------------------------------
package ftifc_pkg;

  localparam int WHOLE_W      = 31;
  localparam int FRAC_IN_W    = 64;
  localparam int ENC_W        = 64;
  localparam int EXP_W        = 11;
  localparam int DEF_FRACTION_BITS = 64;

  localparam int SINGLE_BIAS  = 127;
  localparam int DOUBLE_BIAS  = 1023;
  localparam int SINGLE_MANT  = 23;
  localparam int DOUBLE_MANT  = 52;
  localparam int SINGLE_EXP_W = 8;
  localparam int SINGLE_W     = 32;

  localparam logic FMT_SINGLE = 1'b0;
  localparam logic FMT_DOUBLE = 1'b1;

  typedef logic [ENC_W-1:0] enc_t;
  typedef logic [EXP_W-1:0] exp_t;

endpackage : ftifc_pkg
`default_nettype wire

@@ rtl/core/fixed_to_ieee_float_convert_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fixed-point to IEEE 754 converter core
// Converts a sign-magnitude fixed-point value to single or double format,
// truncating the mantissa.
// ----------------------------------------------------------------------------
// The core accepts one beat in every clock cycle and never raises busy. Each
// result appears on out_encoded and out_is_zero, marked by out_valid, once its
// input beat has passed through the four register stages: input
// capture, leading-one detection, a coarse shift by multiples of sixteen and
// a fine shift with exponent and packing. The receiver cannot stall the
// core, so every result must be taken in the cycle it is shown. The format
// register travels with each beat and should be written only while no beat
// is in flight.
module fixed_to_ieee_float_convert_core
  import ftifc_pkg::*;
#(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  wire                  in_sign,
  input  wire [WHOLE_W-1:0]    in_whole_magnitude,
  input  wire [FRAC_IN_W-1:0]  in_fraction,
  output logic                 out_valid,
  output logic [ENC_W-1:0]     out_encoded,
  output logic                 out_is_zero,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire                  cfg_format_select
);

  localparam int MAG_W = WHOLE_W + FRACTION_BITS;
  localparam int LZ_W  = $clog2(MAG_W);
  localparam int TOP_POS = MAG_W - 1 - FRACTION_BITS;

  function automatic logic [LZ_W-1:0] lead_zeros(input logic [MAG_W-1:0] m);
    logic [LZ_W-1:0] n;
    n = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (m[i]) begin
        n = LZ_W'(MAG_W - 1 - i);
      end
    end
    return n;
  endfunction

  logic fmt_r, fmt_nxt;

  logic             v1_r, s1_r, f1_r;
  logic [MAG_W-1:0] m1_r;

  logic             v2_r, s2_r, f2_r, z2_r;
  logic [MAG_W-1:0] m2_r;
  logic [LZ_W-1:0]  lz2_r;

  logic             v3_r, s3_r, f3_r, z3_r;
  logic [MAG_W-1:0] m3_r;
  logic [LZ_W-1:0]  lz3_r;

  logic             out_valid_r, out_is_zero_r;
  enc_t             out_encoded_r, enc_nxt;

  logic             in_fire;
  logic [MAG_W-1:0] mag_in, coarse, norm;
  logic [LZ_W-1:0]  coarse_amt;
  exp_t             exp_val, bias;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_fire   = start && !busy;
  assign mag_in    = {in_whole_magnitude, in_fraction[FRAC_IN_W-1 -: FRACTION_BITS]};
  assign fmt_nxt   = (cfg_valid && cfg_ready) ? cfg_format_select : fmt_r;

  assign coarse_amt = {lz2_r[LZ_W-1:4], 4'b0000};
  assign coarse     = m2_r << coarse_amt;
  assign norm       = m3_r << lz3_r[3:0];
  assign bias       = (f3_r == FMT_DOUBLE) ? exp_t'(DOUBLE_BIAS) : exp_t'(SINGLE_BIAS);
  assign exp_val    = bias + exp_t'(TOP_POS) - exp_t'(lz3_r);

  always_comb begin
    enc_nxt = '0;
    if (f3_r == FMT_DOUBLE) begin
      enc_nxt[ENC_W-1] = s3_r;
      if (!z3_r) begin
        enc_nxt[ENC_W-2 -: EXP_W]     = exp_val;
        enc_nxt[DOUBLE_MANT-1:0]      = norm[MAG_W-2 -: DOUBLE_MANT];
      end
    end else begin
      enc_nxt[SINGLE_W-1] = s3_r;
      if (!z3_r) begin
        enc_nxt[SINGLE_W-2 -: SINGLE_EXP_W] = exp_val[SINGLE_EXP_W-1:0];
        enc_nxt[SINGLE_MANT-1:0]            = norm[MAG_W-2 -: SINGLE_MANT];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r       <= FMT_SINGLE;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fmt_r       <= fmt_nxt;
      v1_r        <= in_fire;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= in_sign;
    f1_r <= fmt_r;
    m1_r <= mag_in;

    s2_r  <= s1_r;
    f2_r  <= f1_r;
    m2_r  <= m1_r;
    z2_r  <= (m1_r == '0);
    lz2_r <= lead_zeros(m1_r);

    s3_r  <= s2_r;
    f3_r  <= f2_r;
    z3_r  <= z2_r;
    m3_r  <= coarse;
    lz3_r <= lz2_r;

    out_encoded_r <= enc_nxt;
    out_is_zero_r <= z3_r;
  end

  assign out_valid   = out_valid_r;
  assign out_encoded = out_encoded_r;
  assign out_is_zero = out_is_zero_r;

`ifndef SYNTHESIS
  a_valid_from_stage3: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(v3_r))
    else $error("Result beat without a beat in the last stage.");

  a_zero_encoding: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_zero) |-> (out_encoded[62:32] == '0 && out_encoded[30:0] == '0))
    else $error("Zero result carries a nonzero exponent or mantissa.");

  a_single_upper_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(f3_r) == FMT_SINGLE) |-> (out_encoded[63:32] == '0))
    else $error("Single-format result has upper bits set.");
`endif

endmodule : fixed_to_ieee_float_convert_core
`default_nettype wire
